// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clock, off while reset is high
`define CHK_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off while reset is high
`define CHK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/ipv6p_pkg.sv =====
`timescale 1ns / 1ps

package ipv6p_pkg;

   localparam logic [7:0] CHAR_END   = 8'h00;
   localparam logic [7:0] CHAR_COLON = 8'h3A;

   localparam logic [5:0] ADDR_BYTES       = 6'd16;
   localparam logic [2:0] GROUP_MAX_DIGITS = 3'd4;
   localparam int         GROUP_WORDS      = 8;

   typedef logic [15:0] word_type;

   // {is_hex, nibble}
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'b0_0000;
      priority if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end else begin
         r = 5'b0_0000;
      end
      return r;
   endfunction

endpackage

// ===== sv/ipv6_text_address_parser_core.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake                payload
// req_      in         req_valid / req_stall    req_char_in[7:0]
// rsp_      out        rsp_valid / rsp_stall    rsp_addr_high[63:0], rsp_addr_low[63:0],
//                                               rsp_parse_ok
//
// one character per cycle while req_stall is low; input register, then state update and
// result register, so a result becomes valid as its terminator beat leaves the input register.
// reset is synchronous and clears parse state, head/tail words and both valid stages.
// rsp_stall holds the result register; a terminator waiting in the input register
// then raises req_stall, while other characters keep flowing.

module ipv6_text_address_parser_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_addr_high,
   output logic [63:0] rsp_addr_low,
   output logic        rsp_parse_ok
);
   import ipv6p_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff;

   word_type   head_ff [GROUP_WORDS];
   word_type   head_in [GROUP_WORDS];
   word_type   tail_ff [GROUP_WORDS];
   word_type   tail_in [GROUP_WORDS];
   logic [4:0] head_count_ff, head_count_in;
   logic [4:0] tail_count_ff, tail_count_in;
   logic       after_gap_ff, after_gap_in;
   word_type   group_value_ff, group_value_in;
   logic [2:0] group_digits_ff, group_digits_in;
   logic       prev_colon_ff, prev_colon_in;
   logic       at_start_ff, at_start_in;
   logic       failed_ff, failed_in;

   logic         out_valid_ff, out_valid_in;
   logic [127:0] out_addr_ff, out_addr_in;
   logic         out_ok_ff, out_ok_in;

   logic       is_end, is_colon, advance, out_free, take_req;
   logic [4:0] hex;
   logic [4:0] sel_count;
   logic       failed_n;
   logic [127:0] addr_raw;

   assign is_end   = (in_char_ff == CHAR_END);
   assign is_colon = (in_char_ff == CHAR_COLON);
   assign hex      = hex_decode(in_char_ff);
   assign out_free = !out_valid_ff || !rsp_stall;
   // only a terminator needs room in the result register
   assign advance  = in_valid_ff && (!is_end || out_free);
   assign req_stall = in_valid_ff && !advance;
   assign take_req  = req_valid && !req_stall;

   assign in_valid_in = take_req ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   always_comb begin
      for (int i = 0; i < GROUP_WORDS; i++) begin
         head_in[i] = head_ff[i];
         tail_in[i] = tail_ff[i];
      end
      head_count_in   = head_count_ff;
      tail_count_in   = tail_count_ff;
      after_gap_in    = after_gap_ff;
      group_value_in  = group_value_ff;
      group_digits_in = group_digits_ff;
      prev_colon_in   = prev_colon_ff;
      at_start_in     = at_start_ff;
      failed_n        = failed_ff;
      sel_count       = after_gap_ff ? tail_count_ff : head_count_ff;
      addr_raw        = '0;

      if (!failed_ff) begin
         if (is_colon || is_end) begin
            if (group_digits_ff != 3'd0) begin
               if ({1'b0, sel_count} + 6'd2 > ADDR_BYTES) begin
                  failed_n = 1'b1;
               end else begin
                  if (after_gap_ff) begin
                     // tail words stay right-aligned: shift toward the front
                     for (int i = 0; i < GROUP_WORDS - 1; i++) begin
                        tail_in[i] = tail_ff[i + 1];
                     end
                     tail_in[GROUP_WORDS - 1] = group_value_ff;
                     tail_count_in = tail_count_ff + 5'd2;
                  end else begin
                     head_in[head_count_ff[3:1]] = group_value_ff;
                     head_count_in = head_count_ff + 5'd2;
                  end
                  group_value_in  = '0;
                  group_digits_in = 3'd0;
               end
            end else if (!at_start_ff && prev_colon_ff) begin
               if (after_gap_ff && !is_end) begin
                  failed_n = 1'b1;
               end else begin
                  after_gap_in = 1'b1;
               end
            end
            prev_colon_in = is_colon;
         end else begin
            if (!hex[4]) begin
               failed_n = 1'b1;
            end else begin
               group_value_in  = {group_value_ff[11:0], hex[3:0]};
               group_digits_in = group_digits_ff + 3'd1;
               if (group_digits_ff + 3'd1 > GROUP_MAX_DIGITS) begin
                  failed_n = 1'b1;
               end
            end
            prev_colon_in = 1'b0;
         end
         at_start_in = 1'b0;
      end

      if (is_end && !failed_n &&
          ({1'b0, head_count_in} + {1'b0, tail_count_in} > ADDR_BYTES)) begin
         failed_n = 1'b1;
      end
      failed_in = failed_n;

      // head and tail cannot overlap once the length check passed
      for (int i = 0; i < GROUP_WORDS; i++) begin
         addr_raw[127 - 16 * i -: 16] = head_in[i] | tail_in[i];
      end
      out_addr_in = failed_n ? '0 : addr_raw;
      out_ok_in   = !failed_n;

      if (is_end) begin
         for (int i = 0; i < GROUP_WORDS; i++) begin
            head_in[i] = '0;
            tail_in[i] = '0;
         end
         head_count_in   = 5'd0;
         tail_count_in   = 5'd0;
         after_gap_in    = 1'b0;
         group_value_in  = '0;
         group_digits_in = 3'd0;
         prev_colon_in   = 1'b0;
         at_start_in     = 1'b1;
         failed_in       = 1'b0;
      end
   end

   assign out_valid_in = (advance && is_end) ? 1'b1 :
                         (rsp_stall ? out_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         head_count_ff   <= 5'd0;
         tail_count_ff   <= 5'd0;
         after_gap_ff    <= 1'b0;
         group_value_ff  <= '0;
         group_digits_ff <= 3'd0;
         prev_colon_ff   <= 1'b0;
         at_start_ff     <= 1'b1;
         failed_ff       <= 1'b0;
         for (int i = 0; i < GROUP_WORDS; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            head_count_ff   <= head_count_in;
            tail_count_ff   <= tail_count_in;
            after_gap_ff    <= after_gap_in;
            group_value_ff  <= group_value_in;
            group_digits_ff <= group_digits_in;
            prev_colon_ff   <= prev_colon_in;
            at_start_ff     <= at_start_in;
            failed_ff       <= failed_in;
            for (int i = 0; i < GROUP_WORDS; i++) begin
               head_ff[i] <= head_in[i];
               tail_ff[i] <= tail_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         in_char_ff <= req_char_in;
      end
      if (advance && is_end) begin
         out_addr_ff <= out_addr_in;
         out_ok_ff   <= out_ok_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_addr_high = out_addr_ff[127:64];
   assign rsp_addr_low  = out_addr_ff[63:0];
   assign rsp_parse_ok  = out_ok_ff;

endmodule

// ===== sv/ipv6p_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ipv6p_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_addr_high,
   input logic [63:0] rsp_addr_low,
   input logic        rsp_parse_ok
);

   logic         rsp_held;
   logic         rsp_error;
   logic         zero_addr;
   logic [128:0] rsp_payload;

   assign rsp_held    = rsp_valid && rsp_stall;
   assign rsp_error   = rsp_valid && !rsp_parse_ok;
   assign zero_addr   = (rsp_addr_high == 64'd0) && (rsp_addr_low == 64'd0);
   assign rsp_payload = {rsp_addr_high, rsp_addr_low, rsp_parse_ok};

   `CHK_NEXT(a_rsp_valid_holds, rsp_held, rsp_valid, "result beat dropped while stalled")
   `CHK_NEXT(a_rsp_payload_holds, rsp_held, $stable(rsp_payload), "result beat changed")
   `CHK_SAME(a_error_zero_addr, rsp_error, zero_addr, "failed parse carries a nonzero address")
   `CHK_SAME(a_stall_only_on_full_output, req_stall, rsp_held, "input stalled, output free")

endmodule

bind ipv6_text_address_parser_core ipv6p_checker u_ipv6p_checker (.*);

// ===== tb/ipv6_text_address_parser_checker.sv =====
`timescale 1ns / 1ps

module ipv6_text_address_parser_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_char_in,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [63:0] rsp_addr_high,
   input  logic [63:0] rsp_addr_low,
   input  logic        rsp_parse_ok,
   output int          mismatch_count,
   output int          pending_count,
   output int          results_checked,
   output int          parsed_ok_count
);

   import ipv6p_pkg::*;

   typedef struct packed {
      logic [63:0] high;
      logic [63:0] low;
      logic        ok;
   } parsed_addr_type;

   parsed_addr_type pending_addrs[$];

   // running parse state
   logic [7:0]  head_store [16];
   logic [7:0]  tail_store [16];
   logic [4:0]  head_fill;
   logic [4:0]  tail_fill;
   logic [15:0] group_acc;
   logic [2:0]  digit_count;
   logic        gap_seen;
   logic        last_colon;
   logic        first_char;
   logic        parse_failed;

   task automatic clear_parse();
      for (int k = 0; k < 16; k++) begin
         head_store[k] = 8'h00;
         tail_store[k] = 8'h00;
      end
      head_fill    = '0;
      tail_fill    = '0;
      group_acc    = '0;
      digit_count  = '0;
      gap_seen     = 1'b0;
      last_colon   = 1'b0;
      first_char   = 1'b1;
      parse_failed = 1'b0;
   endtask

   task automatic parse_char(input logic [7:0] c);
      logic        is_end;
      logic [3:0]  nib;
      logic        is_hex;
      logic [7:0]  addr_bytes [16];
      parsed_addr_type got;
      is_end = (c == CHAR_END);
      if (!parse_failed) begin
         if (c == CHAR_COLON || is_end) begin
            if (digit_count != 0) begin
               // group goes to the tail once a gap was seen
               if (gap_seen) begin
                  if (int'(tail_fill) + 2 > int'(ADDR_BYTES)) begin
                     parse_failed = 1'b1;
                  end else begin
                     tail_store[tail_fill[3:0]]        = group_acc[15:8];
                     tail_store[tail_fill[3:0] + 4'd1] = group_acc[7:0];
                     tail_fill   = tail_fill + 5'd2;
                     group_acc   = '0;
                     digit_count = '0;
                  end
               end else begin
                  if (int'(head_fill) + 2 > int'(ADDR_BYTES)) begin
                     parse_failed = 1'b1;
                  end else begin
                     head_store[head_fill[3:0]]        = group_acc[15:8];
                     head_store[head_fill[3:0] + 4'd1] = group_acc[7:0];
                     head_fill   = head_fill + 5'd2;
                     group_acc   = '0;
                     digit_count = '0;
                  end
               end
            end else if (!first_char && last_colon) begin
               // a second gap is fine only when the terminator closes a trailing colon
               if (gap_seen && !is_end) begin
                  parse_failed = 1'b1;
               end else begin
                  gap_seen = 1'b1;
               end
            end
            last_colon = (c == CHAR_COLON);
         end else begin
            is_hex = 1'b1;
            nib    = 4'h0;
            if (c >= "0" && c <= "9") begin
               nib = 4'(c - "0");
            end else if (c >= "a" && c <= "f") begin
               nib = 4'(c - "a" + 8'd10);
            end else if (c >= "A" && c <= "F") begin
               nib = 4'(c - "A" + 8'd10);
            end else begin
               is_hex = 1'b0;
            end
            if (!is_hex) begin
               parse_failed = 1'b1;
            end else begin
               group_acc   = {group_acc[11:0], nib};
               digit_count = digit_count + 3'd1;
               if (digit_count > GROUP_MAX_DIGITS) begin
                  parse_failed = 1'b1;
               end
            end
            last_colon = 1'b0;
         end
         first_char = 1'b0;
      end

      if (is_end) begin
         if (!parse_failed && int'(head_fill) + int'(tail_fill) > int'(ADDR_BYTES)) begin
            parse_failed = 1'b1;
         end
         for (int k = 0; k < 16; k++) begin
            addr_bytes[k] = 8'h00;
         end
         if (!parse_failed) begin
            for (int k = 0; k < int'(head_fill); k++) begin
               addr_bytes[k] = head_store[k];
            end
            for (int k = 0; k < int'(tail_fill); k++) begin
               addr_bytes[16 - int'(tail_fill) + k] = tail_store[k];
            end
         end
         got.high = '0;
         got.low  = '0;
         for (int k = 0; k < 8; k++) begin
            got.high = {got.high[55:0], addr_bytes[k]};
            got.low  = {got.low[55:0], addr_bytes[k + 8]};
         end
         got.ok = !parse_failed;
         pending_addrs.push_back(got);
         clear_parse();
      end
   endtask

   always @(posedge clock) begin : watch
      parsed_addr_type want;
      if (reset) begin
         pending_addrs.delete();
         clear_parse();
         mismatch_count  = 0;
         results_checked = 0;
         parsed_ok_count = 0;
      end else begin
         // result side first, so a stray beat is never matched by this edge's terminator
         if (rsp_valid && !rsp_stall) begin
            if (pending_addrs.size() == 0) begin
               mismatch_count++;
               $display("%0t: result beat with nothing pending: high %h low %h ok %b",
                        $time, rsp_addr_high, rsp_addr_low, rsp_parse_ok);
            end else begin
               want = pending_addrs.pop_front();
               results_checked++;
               if (rsp_parse_ok) parsed_ok_count++;
               if (rsp_addr_high !== want.high) begin
                  mismatch_count++;
                  $display("%0t: addr_high expected %h, got %h",
                           $time, want.high, rsp_addr_high);
               end
               if (rsp_addr_low !== want.low) begin
                  mismatch_count++;
                  $display("%0t: addr_low expected %h, got %h",
                           $time, want.low, rsp_addr_low);
               end
               if (rsp_parse_ok !== want.ok) begin
                  mismatch_count++;
                  $display("%0t: parse_ok expected %b, got %b",
                           $time, want.ok, rsp_parse_ok);
               end
            end
         end
         if (req_valid && !req_stall) begin
            parse_char(req_char_in);
         end
      end
      pending_count = pending_addrs.size();
   end

endmodule

// ===== tb/ipv6_text_address_parser_core_tb.sv =====
`timescale 1ns / 1ps

module ipv6_text_address_parser_core_tb;

   import ipv6p_pkg::*;

   localparam int QUIET_LIMIT = 2000;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_in = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   logic [63:0] rsp_addr_high;
   logic [63:0] rsp_addr_low;
   logic        rsp_parse_ok;

   int mismatch_count;
   int pending_count;
   int results_checked;
   int parsed_ok_count;

   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   int chars_sent    = 0;
   int strings_sent  = 0;
   int quiet_cycles  = 0;

   logic [7:0] text[$];

   always #5 clock = ~clock;

   ipv6_text_address_parser_core u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_in   (req_char_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_addr_high (rsp_addr_high),
      .rsp_addr_low  (rsp_addr_low),
      .rsp_parse_ok  (rsp_parse_ok)
   );

   ipv6_text_address_parser_checker u_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_char_in     (req_char_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_addr_high   (rsp_addr_high),
      .rsp_addr_low    (rsp_addr_low),
      .rsp_parse_ok    (rsp_parse_ok),
      .mismatch_count  (mismatch_count),
      .pending_count   (pending_count),
      .results_checked (results_checked),
      .parsed_ok_count (parsed_ok_count)
   );

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
         $display("ipv6_text_address_parser_core_tb: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // called at a falling edge, returns at the falling edge after the beat
   task automatic send_char(input logic [7:0] c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_char_in <= c;
      do @(posedge clock); while (req_stall);
      chars_sent++;
      @(negedge clock);
   endtask

   task automatic queue_text(input string s);
      for (int k = 0; k < s.len(); k++) begin
         text.push_back(s[k]);
      end
   endtask

   task automatic send_text();
      foreach (text[k]) begin
         send_char(text[k]);
      end
      send_char(CHAR_END);
      text.delete();
      strings_sent++;
   endtask

   task automatic build_random_text();
      int kind;
      int groups;
      int gap_at;
      int digits;
      int nib;
      int pos;
      kind = $urandom_range(99);
      if (kind < 15) begin
         // raw noise, any nonzero byte
         repeat ($urandom_range(8, 1)) text.push_back(8'($urandom_range(255, 1)));
      end else begin
         groups = ($urandom_range(3) == 0) ? $urandom_range(10, 8) : $urandom_range(8);
         gap_at = $urandom_range(1) ? int'($urandom_range(groups)) : -1;
         if (gap_at != 0 && $urandom_range(9) == 0) text.push_back(CHAR_COLON);
         for (int g = 0; g < groups; g++) begin
            if (g == gap_at) begin
               text.push_back(CHAR_COLON);
               text.push_back(CHAR_COLON);
            end else if (g > 0) begin
               text.push_back(CHAR_COLON);
            end
            digits = ($urandom_range(19) == 0) ? 5 : $urandom_range(4, 1);
            repeat (digits) begin
               nib = $urandom_range(15);
               if (nib < 10) begin
                  text.push_back(8'("0" + nib));
               end else begin
                  text.push_back(8'(($urandom_range(1) ? "a" : "A") + nib - 10));
               end
            end
         end
         if (gap_at == groups) begin
            text.push_back(CHAR_COLON);
            text.push_back(CHAR_COLON);
         end else if ($urandom_range(9) == 0) begin
            text.push_back(CHAR_COLON);
         end
         // broken form: one stray colon or one random byte
         if (kind < 30 && text.size() > 0) begin
            pos = $urandom_range(text.size() - 1);
            if ($urandom_range(1)) begin
               text.insert(pos, CHAR_COLON);
            end else begin
               text[pos] = 8'($urandom_range(255, 1));
            end
         end
      end
   endtask

   initial begin
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 23;
      rsp_idle_pct  = 67;

      // empty string
      send_text();
      // leading colon, mixed case, gap, trailing colon after the gap
      queue_text(":9Ab::F:");
      send_text();
      // five-digit group, rest ignored
      queue_text("12345:1");
      send_text();
      // second gap, then a top-bit byte that must be ignored
      queue_text("1::2::");
      text.push_back(8'hFF);
      send_text();
      // trailing gap
      queue_text("1::");
      send_text();

      while (chars_sent < 220) begin
         build_random_text();
         send_text();
      end
      send_idle_pct = 67;
      rsp_idle_pct  = 23;
      while (chars_sent < 410) begin
         build_random_text();
         send_text();
      end
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      while (chars_sent < 630 || strings_sent < 50) begin
         build_random_text();
         send_text();
      end
      req_valid <= 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (8) @(negedge clock);

      $display("sent %0d characters in %0d strings under three idle mixes",
               chars_sent, strings_sent);
      $display("checked %0d addresses, %0d parsed ok, %0d rejected",
               results_checked, parsed_ok_count, results_checked - parsed_ok_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("ipv6_text_address_parser_core_tb: PASS");
      end else begin
         $display("ipv6_text_address_parser_core_tb: FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+sv
sv/ipv6p_pkg.sv
sv/ipv6_text_address_parser_core.sv
sv/ipv6p_checker.sv
tb/ipv6_text_address_parser_checker.sv
tb/ipv6_text_address_parser_core_tb.sv
